// ===== hdl/crc32dku_pkg.sv =====
// Shared types, constants and CRC helpers for the device key unlock checker.
package crc32dku_pkg;

	localparam int ID_BYTES      = 16;
	localparam int SECRET_ROW_N  = 3;
	localparam int SECRET_LEN    = 16;
	localparam int SEL_W         = 3;
	localparam int BYTE_IDX_W    = 6;
	localparam int CFG_IDX_W     = 1;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_ID_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_HIGH = 1'b1;

	localparam logic [1:0] MODE_SUBMIT  = 2'd0;
	localparam logic [1:0] MODE_RECHECK = 2'd1;

	localparam logic [7:0] SECRET_ROWS [SECRET_ROW_N][SECRET_LEN] = '{
		'{8'hAB, 8'h48, 8'h90, 8'hC4, 8'h55, 8'hA1, 8'h5C, 8'hF1,
		  8'h11, 8'h2F, 8'h03, 8'h43, 8'h15, 8'h6B, 8'hD7, 8'hF8},
		'{8'h12, 8'h34, 8'h56, 8'h78, 8'h90, 8'hAB, 8'hCD, 8'hEF,
		  8'h10, 8'h02, 8'h30, 8'h04, 8'h50, 8'h06, 8'h70, 8'h08},
		'{8'hAB, 8'h48, 8'h90, 8'hC4, 8'h55, 8'hA1, 8'h5C, 8'hF1,
		  8'h11, 8'h2F, 8'h03, 8'h43, 8'h15, 8'h6B, 8'hD7, 8'hF9}
	};

	typedef enum logic [3:0] {
		DP_NOP,
		DP_INIT,
		DP_ID,
		DP_SAVE_PREFIX,
		DP_SECRET,
		DP_EXPECT,
		DP_SUBMIT,
		DP_RELOAD,
		DP_CHECK,
		DP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t                op;
		logic                  latch;
		logic [SEL_W-1:0]      sel;
		logic [BYTE_IDX_W-1:0] byte_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic             bad;
		logic [SEL_W-1:0] item_sel;
	} dp_status_t;

	function automatic logic [7:0] secret_byte(input logic [SEL_W-1:0] row,
		input logic [BYTE_IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (row < SEL_W'(SECRET_ROW_N) && idx < BYTE_IDX_W'(SECRET_LEN)) begin
			b = SECRET_ROWS[row[1:0]][idx[3:0]];
		end
		return b;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/crc32dku_datapath.sv =====
// Datapath: device ID registers, byte-wide CRC engine, stored keys, flags, result register.
module crc32dku_datapath #(
	parameter int KEY_TYPES    = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [crc32dku_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                          cfg_data,
	input  logic [1:0]                           mode,
	input  logic [1:0]                           key_type,
	input  logic [31:0]                          key_value,
	input  crc32dku_pkg::dp_cmd_t                cmd,
	output crc32dku_pkg::dp_status_t             status,
	output logic [31:0]                          expected_key,
	output logic [31:0]                          stored_key,
	output logic                                 key_matches,
	output logic [2:0]                           unlock_flags,
	output logic                                 bad_type
);

	localparam int TW = (KEY_TYPES > 1) ? $clog2(KEY_TYPES) : 1;

	logic [63:0]          id_low_q;
	logic [63:0]          id_high_q;
	logic [1:0]           mode_q;
	logic [1:0]           type_q;
	logic [31:0]          key_q;
	logic [31:0]          crc_q;
	logic [31:0]          prefix_q;
	logic [31:0]          exp_q;
	logic [31:0]          saved_q [KEY_TYPES];
	logic [KEY_TYPES-1:0] flags_q;
	logic [31:0]          out_exp_q;
	logic [31:0]          out_stored_q;
	logic                 out_match_q;
	logic [2:0]           out_flags_q;
	logic                 out_bad_q;

	logic                 bad;
	logic [TW-1:0]        sel;
	logic [127:0]         id_all;
	logic [7:0]           id_byte;
	logic [7:0]           sec_byte;
	logic [7:0]           flags_pad;

	assign bad       = ({1'b0, type_q} >= 3'(KEY_TYPES > 4 ? 4 : KEY_TYPES));
	assign sel       = cmd.sel[TW-1:0];
	assign id_all    = {id_high_q, id_low_q};
	assign id_byte   = id_all[8*cmd.byte_idx[3:0] +: 8];
	assign sec_byte  = crc32dku_pkg::secret_byte(cmd.sel, cmd.byte_idx);
	assign flags_pad = 8'(flags_q);

	assign status.mode     = mode_q;
	assign status.bad      = bad;
	assign status.item_sel = bad ? '0 : crc32dku_pkg::SEL_W'(type_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_low_q  <= '0;
			id_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				crc32dku_pkg::CFG_ID_LOW:  id_low_q  <= cfg_data;
				crc32dku_pkg::CFG_ID_HIGH: id_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			type_q <= key_type;
			key_q  <= key_value;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			crc32dku_pkg::DP_INIT:        crc_q    <= crc32dku_pkg::CRC_ALL_ONES;
			crc32dku_pkg::DP_ID:          crc_q    <= crc32dku_pkg::crc_byte(crc_q, id_byte);
			crc32dku_pkg::DP_SAVE_PREFIX: prefix_q <= crc_q;
			crc32dku_pkg::DP_SECRET:      crc_q    <= crc32dku_pkg::crc_byte(crc_q, sec_byte);
			crc32dku_pkg::DP_EXPECT:      exp_q    <= ~crc_q;
			crc32dku_pkg::DP_RELOAD:      crc_q    <= prefix_q;
			crc32dku_pkg::DP_LOAD_OUT: begin
				out_exp_q    <= bad ? 32'h0 : exp_q;
				out_stored_q <= bad ? 32'h0 : saved_q[sel];
				out_match_q  <= bad ? 1'b0 : flags_q[sel];
				out_flags_q  <= flags_pad[2:0];
				out_bad_q    <= bad;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			for (int i = 0; i < KEY_TYPES; i++) begin
				saved_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				crc32dku_pkg::DP_SUBMIT: begin
					saved_q[sel] <= key_q;
					flags_q[sel] <= (key_q == exp_q);
				end
				crc32dku_pkg::DP_CHECK: flags_q[sel] <= (saved_q[sel] == ~crc_q);
				default: ;
			endcase
		end
	end

	assign expected_key = out_exp_q;
	assign stored_key   = out_stored_q;
	assign key_matches  = out_match_q;
	assign unlock_flags = out_flags_q;
	assign bad_type     = out_bad_q;

endmodule

// ===== hdl/crc32dku_ctrl.sv =====
// Controller: sequences the CRC passes, the key update and the result beat.
module crc32dku_ctrl #(
	parameter int KEY_TYPES    = 3,
	parameter int SECRET_BYTES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  crc32dku_pkg::dp_status_t status,
	output crc32dku_pkg::dp_cmd_t    cmd
);

	localparam int TW = (KEY_TYPES > 1) ? $clog2(KEY_TYPES) : 1;
	localparam int CW = (SECRET_BYTES > crc32dku_pkg::ID_BYTES) ? $clog2(SECRET_BYTES) : 4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PREFIX,
		S_SAVE,
		S_SECRET,
		S_EXPECT,
		S_SUBMIT,
		S_RELOAD,
		S_RSECRET,
		S_CHECK,
		S_OUTPUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] sel_q;
	logic          out_valid_q;

	logic          accept;
	logic          out_free;
	logic          id_last;
	logic          sec_last;
	logic          type_last;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign id_last   = (cnt_q == CW'(crc32dku_pkg::ID_BYTES - 1));
	assign sec_last  = (cnt_q == CW'(SECRET_BYTES - 1));
	assign type_last = (sel_q == TW'(KEY_TYPES - 1));

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.latch    = accept;
		cmd.sel      = crc32dku_pkg::SEL_W'(sel_q);
		cmd.byte_idx = crc32dku_pkg::BYTE_IDX_W'(cnt_q);
		case (state_q)
			S_DECODE:  cmd.op = crc32dku_pkg::DP_INIT;
			S_PREFIX:  cmd.op = crc32dku_pkg::DP_ID;
			S_SAVE:    cmd.op = crc32dku_pkg::DP_SAVE_PREFIX;
			S_SECRET:  cmd.op = crc32dku_pkg::DP_SECRET;
			S_EXPECT:  cmd.op = crc32dku_pkg::DP_EXPECT;
			S_SUBMIT:  cmd.op = crc32dku_pkg::DP_SUBMIT;
			S_RELOAD:  cmd.op = crc32dku_pkg::DP_RELOAD;
			S_RSECRET: cmd.op = crc32dku_pkg::DP_SECRET;
			S_CHECK:   cmd.op = crc32dku_pkg::DP_CHECK;
			S_OUTPUT:  cmd.op = out_free ? crc32dku_pkg::DP_LOAD_OUT : crc32dku_pkg::DP_NOP;
			default:   cmd.op = crc32dku_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUTPUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					cnt_q   <= '0;
					sel_q   <= status.item_sel[TW-1:0];
					state_q <= status.bad ? S_OUTPUT : S_PREFIX;
				end
				S_PREFIX: begin
					cnt_q <= id_last ? '0 : cnt_q + 1'b1;
					if (id_last) begin
						state_q <= S_SAVE;
					end
				end
				S_SAVE: begin
					state_q <= S_SECRET;
				end
				S_SECRET: begin
					cnt_q <= sec_last ? '0 : cnt_q + 1'b1;
					if (sec_last) begin
						state_q <= S_EXPECT;
					end
				end
				S_EXPECT: begin
					if (status.mode == crc32dku_pkg::MODE_SUBMIT) begin
						state_q <= S_SUBMIT;
					end else if (status.mode == crc32dku_pkg::MODE_RECHECK) begin
						sel_q   <= '0;
						state_q <= S_RELOAD;
					end else begin
						state_q <= S_OUTPUT;
					end
				end
				S_SUBMIT: begin
					state_q <= S_OUTPUT;
				end
				S_RELOAD: begin
					cnt_q   <= '0;
					state_q <= S_RSECRET;
				end
				S_RSECRET: begin
					cnt_q <= sec_last ? '0 : cnt_q + 1'b1;
					if (sec_last) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (type_last) begin
						sel_q   <= status.item_sel[TW-1:0];
						state_q <= S_OUTPUT;
					end else begin
						sel_q   <= sel_q + 1'b1;
						state_q <= S_RELOAD;
					end
				end
				S_OUTPUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DECODE)
		else $error("accepted beat did not start decode");

	a_output_beat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUTPUT && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("result beat not presented");

	a_check_sel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> sel_q <= TW'(KEY_TYPES - 1))
		else $error("recheck type index out of range");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("input taken while busy");

endmodule

// ===== hdl/crc32_device_key_unlock_top.sv =====
// Top level of the CRC-32 device key unlock checker.
// Use: write device_id_low (index 0) and device_id_high (index 1) on the cfg
// channel while idle; cfg_ready is always high. Each input beat (mode,
// key_type, key_value) yields exactly one result beat.
// Each item runs one byte of CRC per cycle through a single byte-wide engine:
// 16 device-ID bytes then SECRET_BYTES secret bytes for the addressed type.
// A submit stores key_value and its match flag for the addressed type; a query
// skips that step. A recheck reruns the secret bytes for every key type from
// the saved ID prefix and refreshes each unlock flag. A bad key_type skips the
// CRC passes and goes straight to the result. One item is in work at a time;
// in_stall is high from acceptance until the result is loaded.
// The result register frees the input side: a new item is accepted while the
// previous result waits. While out_stall is high the result holds, and a
// following item waits in its final step until the slot frees.
// Reset clears the device ID, stored keys and unlock flags, and drops out_valid.
module crc32_device_key_unlock_top #(
	parameter int KEY_TYPES    = 3,
	parameter int SECRET_BYTES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [crc32dku_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         mode,
	input  logic [1:0]                         key_type,
	input  logic [31:0]                        key_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [31:0]                        expected_key,
	output logic [31:0]                        stored_key,
	output logic                               key_matches,
	output logic [2:0]                         unlock_flags,
	output logic                               bad_type
);

	crc32dku_pkg::dp_cmd_t    cmd;
	crc32dku_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	crc32dku_ctrl #(
		.KEY_TYPES    (KEY_TYPES),
		.SECRET_BYTES (SECRET_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	crc32dku_datapath #(
		.KEY_TYPES    (KEY_TYPES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.key_type     (key_type),
		.key_value    (key_value),
		.cmd          (cmd),
		.status       (status),
		.expected_key (expected_key),
		.stored_key   (stored_key),
		.key_matches  (key_matches),
		.unlock_flags (unlock_flags),
		.bad_type     (bad_type)
	);

endmodule
